// ===== src/timer_slot_deadline_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// timer slot deadline table assertion macros
// shared concurrent assertion forms, clocked with async active-low reset
// ----------------------------------------------------------------------------
`ifndef TIMER_SLOT_DEADLINE_TABLE_TOP_MACROS_SVH
`define TIMER_SLOT_DEADLINE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define TSDT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSDT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tsdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdt_pkg
// shared types and constants of the timer slot deadline table
// ----------------------------------------------------------------------------
`default_nettype none

package tsdt_pkg;

    localparam int SLOTS_DEF = 256;
    localparam logic [19:0] TICKS_MAX = 20'd1000000;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_START   = 3'd1,
        REQ_STOP    = 3'd2,
        REQ_RESTART = 3'd3,
        REQ_QUERY   = 3'd4,
        REQ_FIRE    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DUR = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_SLOT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SRCH,
        S_CHK,
        S_UN_NRD,
        S_UN_NWR,
        S_UN_PRD,
        S_UN_PWR,
        S_ARM,
        S_WALK,
        S_LINK_S,
        S_LINK_N,
        S_LINK_P,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  earliest_slot;
        logic        expired;
        logic [15:0] remaining_sec;
        logic [7:0]  result_slot;
        logic [1:0]  status;
    } res_t;

endpackage

`default_nettype wire

// ===== src/tsdt_engine.sv =====
// ----------------------------------------------------------------------------
// tsdt_engine
// slot memory, time base and the sequencer for search, unlink and insert
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_slot_deadline_table_top_macros.svh"

module tsdt_engine #(
    parameter int SLOTS = tsdt_pkg::SLOTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        in_req,
    input  wire logic [7:0]        in_slot,
    input  wire logic [15:0]       in_dur,
    input  wire logic [19:0]       ticks_per_sec,
    input  wire logic              out_free,
    output logic                   res_valid,
    output tsdt_pkg::res_t         res
);

    localparam int SW = $clog2(SLOTS);

    typedef struct packed {
        logic          act;
        logic [15:0]   dur;
        logic [31:0]   dsec;
        logic [19:0]   dfrac;
        logic [SW-1:0] nxt;
        logic [SW-1:0] prv;
    } rec_t;

    rec_t mem [SLOTS];
    rec_t rd_data_reg;

    logic          we;
    logic [SW-1:0] waddr;
    rec_t          wdata;
    logic [SW-1:0] raddr;

    tsdt_pkg::state_t state_reg, state_next;

    logic [2:0]    req_reg, req_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] p_reg, p_next;
    logic [SW-1:0] n_reg, n_next;
    logic [SW-1:0] clr_reg, clr_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] search_reg, search_next;
    rec_t          prec_reg, prec_next;
    rec_t          nrec_reg, nrec_next;
    logic [15:0]   tdur_reg, tdur_next;
    logic [31:0]   tsec_reg, tsec_next;
    logic [19:0]   tfrac_reg, tfrac_next;
    logic [31:0]   now_sec_reg, now_sec_next;
    logic [19:0]   now_frac_reg, now_frac_next;
    logic [1:0]    status_reg, status_next;
    logic [SW-1:0] rslot_reg, rslot_next;
    logic [15:0]   remain_reg, remain_next;
    logic          expired_reg, expired_next;

    logic          accept;
    logic          slot_ok;
    logic [SW-1:0] cur_wrap;
    logic          later;
    logic          q_ahead;
    logic [31:0]   q_diff;
    rec_t          rec_mod;

    assign accept   = in_valid && in_ready;
    assign slot_ok  = (in_slot != 8'd0) && (32'(in_slot) < SLOTS);
    assign cur_wrap = (cur_reg == SW'(SLOTS - 1)) ? SW'(1) : cur_reg + SW'(1);
    assign later    = (rd_data_reg.dsec > tsec_reg) ||
                      ((rd_data_reg.dsec == tsec_reg) && (rd_data_reg.dfrac > tfrac_reg));
    assign q_ahead  = (rd_data_reg.dsec > now_sec_reg) ||
                      ((rd_data_reg.dsec == now_sec_reg) && (rd_data_reg.dfrac >= now_frac_reg));
    assign q_diff   = rd_data_reg.dsec - now_sec_reg
                      - 32'(rd_data_reg.dfrac < now_frac_reg);

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsdt_pkg::S_CLEAR:
            begin
                if (clr_reg == SW'(SLOTS - 1))
                    state_next = tsdt_pkg::S_IDLE;
            end
            tsdt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_req)
                        tsdt_pkg::REQ_START:
                            state_next = (in_dur == 16'd0) ? tsdt_pkg::S_DONE : tsdt_pkg::S_SRCH;
                        tsdt_pkg::REQ_STOP, tsdt_pkg::REQ_RESTART,
                        tsdt_pkg::REQ_QUERY, tsdt_pkg::REQ_FIRE:
                            state_next = slot_ok ? tsdt_pkg::S_CHK : tsdt_pkg::S_DONE;
                        default:
                            state_next = tsdt_pkg::S_DONE;
                    endcase
                end
            end
            tsdt_pkg::S_SRCH:
            begin
                if (!rd_data_reg.act)
                    state_next = tsdt_pkg::S_ARM;
                else if (cnt_reg == SW'(SLOTS - 2))
                    state_next = tsdt_pkg::S_DONE;
            end
            tsdt_pkg::S_CHK:
            begin
                if (!rd_data_reg.act || req_reg == tsdt_pkg::REQ_QUERY)
                    state_next = tsdt_pkg::S_DONE;
                else if (rd_data_reg.nxt != '0)
                    state_next = tsdt_pkg::S_UN_NRD;
                else
                    state_next = tsdt_pkg::S_UN_PRD;
            end
            tsdt_pkg::S_UN_NRD: state_next = tsdt_pkg::S_UN_NWR;
            tsdt_pkg::S_UN_NWR: state_next = tsdt_pkg::S_UN_PRD;
            tsdt_pkg::S_UN_PRD:
            begin
                if (p_reg != '0)
                    state_next = tsdt_pkg::S_UN_PWR;
                else if (req_reg == tsdt_pkg::REQ_RESTART)
                    state_next = tsdt_pkg::S_ARM;
                else
                    state_next = tsdt_pkg::S_DONE;
            end
            tsdt_pkg::S_UN_PWR:
            begin
                state_next = (req_reg == tsdt_pkg::REQ_RESTART) ? tsdt_pkg::S_ARM
                                                                : tsdt_pkg::S_DONE;
            end
            tsdt_pkg::S_ARM:
            begin
                state_next = (head_reg == '0) ? tsdt_pkg::S_LINK_S : tsdt_pkg::S_WALK;
            end
            tsdt_pkg::S_WALK:
            begin
                if (later || rd_data_reg.nxt == '0)
                    state_next = tsdt_pkg::S_LINK_S;
            end
            tsdt_pkg::S_LINK_S:
            begin
                state_next = (n_reg != '0) ? tsdt_pkg::S_LINK_N : tsdt_pkg::S_LINK_P;
            end
            tsdt_pkg::S_LINK_N: state_next = tsdt_pkg::S_LINK_P;
            tsdt_pkg::S_LINK_P: state_next = tsdt_pkg::S_DONE;
            tsdt_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = tsdt_pkg::S_IDLE;
            end
            default: state_next = tsdt_pkg::S_IDLE;
        endcase
    end

    // memory control and data registers
    always_comb
    begin
        we            = 1'b0;
        waddr         = '0;
        wdata         = rd_data_reg;
        raddr         = '0;
        rec_mod       = rd_data_reg;
        req_next      = req_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        clr_next      = clr_reg;
        head_next     = head_reg;
        search_next   = search_reg;
        prec_next     = prec_reg;
        nrec_next     = nrec_reg;
        tdur_next     = tdur_reg;
        tsec_next     = tsec_reg;
        tfrac_next    = tfrac_reg;
        now_sec_next  = now_sec_reg;
        now_frac_next = now_frac_reg;
        status_next   = status_reg;
        rslot_next    = rslot_reg;
        remain_next   = remain_reg;
        expired_next  = expired_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            tsdt_pkg::S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + SW'(1);
            end
            tsdt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                raddr    = (in_req == tsdt_pkg::REQ_START) ? search_reg : SW'(in_slot);
                if (accept)
                begin
                    req_next     = in_req;
                    slot_next    = SW'(in_slot);
                    cur_next     = search_reg;
                    cnt_next     = '0;
                    tdur_next    = in_dur;
                    tsec_next    = now_sec_reg + 32'(in_dur);
                    tfrac_next   = now_frac_reg;
                    status_next  = tsdt_pkg::ST_OK;
                    rslot_next   = '0;
                    remain_next  = '0;
                    expired_next = 1'b0;
                    case (in_req)
                        tsdt_pkg::REQ_TICK:
                        begin
                            if ({1'b0, now_frac_reg} + 21'd1 >= {1'b0, ticks_per_sec})
                            begin
                                now_frac_next = '0;
                                now_sec_next  = now_sec_reg + 32'd1;
                            end
                            else
                            begin
                                now_frac_next = now_frac_reg + 20'd1;
                            end
                        end
                        tsdt_pkg::REQ_START:
                        begin
                            if (in_dur == 16'd0)
                                status_next = tsdt_pkg::ST_ZERO_DUR;
                        end
                        tsdt_pkg::REQ_STOP, tsdt_pkg::REQ_RESTART,
                        tsdt_pkg::REQ_QUERY, tsdt_pkg::REQ_FIRE:
                        begin
                            if (!slot_ok)
                                status_next = tsdt_pkg::ST_BAD_SLOT;
                        end
                        default: ;
                    endcase
                end
            end
            tsdt_pkg::S_SRCH:
            begin
                raddr = cur_wrap;
                if (!rd_data_reg.act)
                begin
                    slot_next   = cur_reg;
                    search_next = cur_wrap;
                end
                else if (cnt_reg == SW'(SLOTS - 2))
                begin
                    status_next = tsdt_pkg::ST_FULL;
                end
                else
                begin
                    cur_next = cur_wrap;
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            tsdt_pkg::S_CHK:
            begin
                if (!rd_data_reg.act)
                begin
                    status_next = tsdt_pkg::ST_BAD_SLOT;
                end
                else if (req_reg == tsdt_pkg::REQ_QUERY)
                begin
                    if (q_ahead)
                        remain_next = (q_diff > 32'd65535) ? 16'hFFFF : q_diff[15:0];
                end
                else
                begin
                    n_next     = rd_data_reg.nxt;
                    p_next     = rd_data_reg.prv;
                    tdur_next  = rd_data_reg.dur;
                    tsec_next  = now_sec_reg + 32'(rd_data_reg.dur);
                    tfrac_next = now_frac_reg;
                    if (req_reg != tsdt_pkg::REQ_RESTART)
                    begin
                        rec_mod.act = 1'b0;
                        we          = 1'b1;
                        waddr       = slot_reg;
                        wdata       = rec_mod;
                    end
                    if (req_reg == tsdt_pkg::REQ_FIRE)
                        expired_next = 1'b1;
                end
            end
            tsdt_pkg::S_UN_NRD:
            begin
                raddr = n_reg;
            end
            tsdt_pkg::S_UN_NWR:
            begin
                rec_mod.prv = p_reg;
                we          = 1'b1;
                waddr       = n_reg;
                wdata       = rec_mod;
            end
            tsdt_pkg::S_UN_PRD:
            begin
                raddr = p_reg;
                if (p_reg == '0)
                    head_next = n_reg;
            end
            tsdt_pkg::S_UN_PWR:
            begin
                rec_mod.nxt = n_reg;
                we          = 1'b1;
                waddr       = p_reg;
                wdata       = rec_mod;
            end
            tsdt_pkg::S_ARM:
            begin
                raddr  = head_reg;
                p_next = '0;
                n_next = head_reg;
            end
            tsdt_pkg::S_WALK:
            begin
                raddr = rd_data_reg.nxt;
                if (later)
                begin
                    nrec_next = rd_data_reg;
                end
                else
                begin
                    p_next    = n_reg;
                    prec_next = rd_data_reg;
                    n_next    = rd_data_reg.nxt;
                end
            end
            tsdt_pkg::S_LINK_S:
            begin
                we          = 1'b1;
                waddr       = slot_reg;
                wdata.act   = 1'b1;
                wdata.dur   = tdur_reg;
                wdata.dsec  = tsec_reg;
                wdata.dfrac = tfrac_reg;
                wdata.nxt   = n_reg;
                wdata.prv   = p_reg;
                rslot_next  = slot_reg;
            end
            tsdt_pkg::S_LINK_N:
            begin
                we        = 1'b1;
                waddr     = n_reg;
                wdata     = nrec_reg;
                wdata.prv = slot_reg;
            end
            tsdt_pkg::S_LINK_P:
            begin
                if (p_reg != '0)
                begin
                    we        = 1'b1;
                    waddr     = p_reg;
                    wdata     = prec_reg;
                    wdata.nxt = slot_reg;
                end
                else
                begin
                    head_next = slot_reg;
                end
            end
            tsdt_pkg::S_DONE:
            begin
                res_valid = out_free;
            end
            default: ;
        endcase
    end

    assign res.status        = status_reg;
    assign res.result_slot   = 8'(rslot_reg);
    assign res.remaining_sec = remain_reg;
    assign res.expired       = expired_reg;
    assign res.earliest_slot = 8'(head_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsdt_pkg::S_CLEAR;
            clr_reg      <= '0;
            head_reg     <= '0;
            search_reg   <= SW'(1);
            now_sec_reg  <= '0;
            now_frac_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            head_reg     <= head_next;
            search_reg   <= search_next;
            now_sec_reg  <= now_sec_next;
            now_frac_reg <= now_frac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        cnt_reg     <= cnt_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        prec_reg    <= prec_next;
        nrec_reg    <= nrec_next;
        tdur_reg    <= tdur_next;
        tsec_reg    <= tsec_next;
        tfrac_reg   <= tfrac_next;
        status_reg  <= status_next;
        rslot_reg   <= rslot_next;
        remain_reg  <= remain_next;
        expired_reg <= expired_next;
    end

    `TSDT_ASSERT_IMPL(a_res_room, clk, rst_n, res_valid, out_free, "result issued with output full")
    `TSDT_ASSERT_NEXT(a_one_item, clk, rst_n, accept, !in_ready, "second request taken while busy")
    `TSDT_ASSERT_IMPL(a_start_slot, clk, rst_n, res_valid && (req_reg == tsdt_pkg::REQ_START) && (status_reg == tsdt_pkg::ST_OK), rslot_reg != '0, "start ok without a slot")
    `TSDT_ASSERT_IMPL(a_search_ptr, clk, rst_n, 1'b1, search_reg != '0, "search pointer on reserved slot")

endmodule

`default_nettype wire

// ===== src/timer_slot_deadline_table_top.sv =====
// ----------------------------------------------------------------------------
// timer_slot_deadline_table_top
// timer slot table with a deadline-sorted queue of armed slots
// ----------------------------------------------------------------------------
// requests arrive on the s_ stream: tuser carries the request kind, tdata the
// slot and the duration. one result per request leaves on the m_ stream.
// sub_ticks_per_second is written on the cfg_ channel; the user must write
// it only while idle, the block itself does not enforce it. one request
// is worked on at a time; the slot records sit in one memory with a
// registered read, so a request works through the memory step by step:
//   tick, bad or unused request, zero duration, query: no queue change
//   stop and fire: unlink from the queue
//   start: free slot search, then queue walk
//   restart: unlink, then queue walk
// after reset the block sweeps the memory clearing every slot, with
// s_tready low; cfg writes are taken during the sweep.
// a finished result waits in an output register, so the next request is
// taken while m_tready is low; a further result waits until it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_slot_deadline_table_top #(
    parameter int SLOTS = tsdt_pkg::SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // timer_slot[7:0], duration_sec[23:8]
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // status[1:0], result_slot[9:2],
                                        // remaining_sec[25:10], expired[26],
                                        // earliest_slot[34:27], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [19:0] cfg_data
);

    logic [19:0]    tps_reg, tps_next;
    logic           ovalid_reg, ovalid_next;
    tsdt_pkg::res_t odata_reg, odata_next;
    logic           out_free;
    logic           res_valid;
    tsdt_pkg::res_t res;

    assign cfg_ready = 1'b1;
    assign out_free  = !ovalid_reg || m_tready;

    // out of range rate values clamp into 1 .. 1000000
    always_comb
    begin
        tps_next = tps_reg;
        if (cfg_valid)
        begin
            if (cfg_data == 20'd0)
                tps_next = 20'd1;
            else if (cfg_data > tsdt_pkg::TICKS_MAX)
                tps_next = tsdt_pkg::TICKS_MAX;
            else
                tps_next = cfg_data;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (res_valid)
        begin
            ovalid_next = 1'b1;
            odata_next  = res;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    tsdt_engine #(
        .SLOTS(SLOTS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req       (s_tuser),
        .in_slot      (s_tdata[7:0]),
        .in_dur       (s_tdata[23:8]),
        .ticks_per_sec(tps_reg),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, odata_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg    <= tsdt_pkg::TICKS_MAX;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            tps_reg    <= tps_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

endmodule

`default_nettype wire
